// ----- design/yuvrgb_pkg.sv -----
// Package: shared constants, types and state encoding for the YUV 4:2:0 to RGB block.
package yuvrgb_pkg;

  localparam int MaxWidth   = 160;
  localparam int MaxHeight  = 120;
  localparam int FrameDepth = MaxWidth * MaxHeight * 3 / 2;
  localparam int AddrW      = $clog2(FrameDepth);
  localparam int WidthW     = 8;
  localparam int HeightW    = 7;
  localparam int ByteW      = 8;
  localparam int CfgIdxW    = 2;
  localparam int SumW       = 20;

  localparam logic [WidthW-1:0]  FrameWidthRst  = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] FrameHeightRst = HeightW'(MaxHeight);

  localparam logic CmdStore   = 1'b0;
  localparam logic CmdConvert = 1'b1;

  localparam logic ModeWebcam = 1'b0;
  localparam logic ModeStudio = 1'b1;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRangeMode   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YADDR,
    ST_SIZE,
    ST_CADDR,
    ST_UADDR,
    ST_VADDR,
    ST_UGET,
    ST_MATH
  } ctrl_state_e;

  typedef struct packed {
    logic wr_mem;
    logic load;
    logic yaddr;
    logic size;
    logic caddr;
    logic uaddr;
    logic vaddr;
    logic uget;
    logic math;
    logic sum;
  } dp_cmd_t;

endpackage

// ----- design/yuv420p_frame_to_rgb_pixel_top.sv -----
// Top level: planar YUV 4:2:0 frame store with per-pixel BT.601 RGB conversion.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------------
//  command  | start_i, busy_o              | command_i, byte_offset_i, byte_value_i,
//           |                              | pixel_x_i, pixel_y_i
//  result   | valid_o (one-cycle strobe)   | red_o, green_o, blue_o
//  config   | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// A store item completes at its accept edge; busy_o stays low.
// A convert item holds busy_o through the YADDR to MATH states and the final sum; valid_o strobes as busy_o drops;
// the single-port frame memory takes Y, U and V reads one after another.
// rst_ni clears control and configuration; frame memory contents are undefined until written.
// Results cannot be stalled; config writes are always ready.
module yuv420p_frame_to_rgb_pixel_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              command_i,
  input  logic [yuvrgb_pkg::AddrW-1:0]      byte_offset_i,
  input  logic [yuvrgb_pkg::ByteW-1:0]      byte_value_i,
  input  logic [yuvrgb_pkg::WidthW-1:0]     pixel_x_i,
  input  logic [yuvrgb_pkg::HeightW-1:0]    pixel_y_i,
  output logic                              valid_o,
  output logic [yuvrgb_pkg::ByteW-1:0]      red_o,
  output logic [yuvrgb_pkg::ByteW-1:0]      green_o,
  output logic [yuvrgb_pkg::ByteW-1:0]      blue_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [yuvrgb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [yuvrgb_pkg::WidthW-1:0]     cfg_data_i
);

  yuvrgb_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  yuvrgb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .busy_o    (busy_o),
    .cmd_o     (cmd)
  );

  yuvrgb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .byte_offset_i (byte_offset_i),
    .byte_value_i  (byte_value_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .valid_o       (valid_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o)
  );

endmodule

// ----- design/yuvrgb_ctrl.sv -----
// Controller: issues store writes and sequences frame reads and arithmetic for one convert item.
module yuvrgb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               command_i,
  output logic               busy_o,
  output yuvrgb_pkg::dp_cmd_t cmd_o
);

  yuvrgb_pkg::ctrl_state_e state_q, state_d;
  logic                    sum_q, sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= yuvrgb_pkg::ST_IDLE;
      sum_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sum_d   = 1'b0;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      yuvrgb_pkg::ST_IDLE: begin
        busy_o = sum_q;
        cmd_o.sum = sum_q;
        if (start_i && !sum_q) begin
          if (command_i == yuvrgb_pkg::CmdConvert) begin
            cmd_o.load = 1'b1;
            state_d    = yuvrgb_pkg::ST_YADDR;
          end else begin
            cmd_o.wr_mem = 1'b1;
          end
        end
      end
      yuvrgb_pkg::ST_YADDR: begin
        cmd_o.yaddr = 1'b1;
        state_d     = yuvrgb_pkg::ST_SIZE;
      end
      yuvrgb_pkg::ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = yuvrgb_pkg::ST_CADDR;
      end
      yuvrgb_pkg::ST_CADDR: begin
        cmd_o.caddr = 1'b1;
        state_d     = yuvrgb_pkg::ST_UADDR;
      end
      yuvrgb_pkg::ST_UADDR: begin
        cmd_o.uaddr = 1'b1;
        state_d     = yuvrgb_pkg::ST_VADDR;
      end
      yuvrgb_pkg::ST_VADDR: begin
        cmd_o.vaddr = 1'b1;
        state_d     = yuvrgb_pkg::ST_UGET;
      end
      yuvrgb_pkg::ST_UGET: begin
        cmd_o.uget = 1'b1;
        state_d    = yuvrgb_pkg::ST_MATH;
      end
      yuvrgb_pkg::ST_MATH: begin
        cmd_o.math = 1'b1;
        sum_d      = 1'b1;
        state_d    = yuvrgb_pkg::ST_IDLE;
      end
      default: begin
        state_d = yuvrgb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/yuvrgb_datapath.sv -----
// Datapath: configuration registers, frame memory, address math and color conversion.
module yuvrgb_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  yuvrgb_pkg::dp_cmd_t                cmd_i,
  input  logic                               cfg_we_i,
  input  logic [yuvrgb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [yuvrgb_pkg::WidthW-1:0]      cfg_data_i,
  input  logic [yuvrgb_pkg::AddrW-1:0]       byte_offset_i,
  input  logic [yuvrgb_pkg::ByteW-1:0]       byte_value_i,
  input  logic [yuvrgb_pkg::WidthW-1:0]      pixel_x_i,
  input  logic [yuvrgb_pkg::HeightW-1:0]     pixel_y_i,
  output logic                               valid_o,
  output logic [yuvrgb_pkg::ByteW-1:0]       red_o,
  output logic [yuvrgb_pkg::ByteW-1:0]       green_o,
  output logic [yuvrgb_pkg::ByteW-1:0]       blue_o
);

  localparam int AddrW   = yuvrgb_pkg::AddrW;
  localparam int WidthW  = yuvrgb_pkg::WidthW;
  localparam int HeightW = yuvrgb_pkg::HeightW;
  localparam int ByteW   = yuvrgb_pkg::ByteW;
  localparam int SumW    = yuvrgb_pkg::SumW;

  function automatic logic [ByteW-1:0] clip8(input logic signed [SumW-1:0] s);
    logic signed [SumW-9:0] q;
    q = $signed(s[SumW-1:8]);
    // sums below -65536 wrap and saturate high
    if (q < -256) begin
      clip8 = '1;
    end else if (q <= 0) begin
      clip8 = '0;
    end else if (q >= 255) begin
      clip8 = '1;
    end else begin
      clip8 = q[ByteW-1:0];
    end
  endfunction

  logic [WidthW-1:0]  frame_width_q;
  logic [HeightW-1:0] frame_height_q;
  logic               range_mode_q;
  logic               valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= yuvrgb_pkg::FrameWidthRst;
      frame_height_q <= yuvrgb_pkg::FrameHeightRst;
      range_mode_q   <= yuvrgb_pkg::ModeWebcam;
      valid_q        <= 1'b0;
    end else begin
      valid_q <= cmd_i.sum;
      if (cfg_we_i) begin
        case (cfg_index_i)
          yuvrgb_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i;
          yuvrgb_pkg::RegFrameHeight: frame_height_q <= cfg_data_i[HeightW-1:0];
          yuvrgb_pkg::RegRangeMode:   range_mode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;
  logic [WidthW-1:0]  w_clamp;
  logic [HeightW-1:0] h_clamp;

  always_comb begin
    if (frame_width_q > WidthW'(yuvrgb_pkg::MaxWidth)) begin
      w_clamp = WidthW'(yuvrgb_pkg::MaxWidth);
    end else if (frame_width_q < WidthW'(2)) begin
      w_clamp = WidthW'(2);
    end else begin
      w_clamp = frame_width_q;
    end
    if (frame_height_q > HeightW'(yuvrgb_pkg::MaxHeight)) begin
      h_clamp = HeightW'(yuvrgb_pkg::MaxHeight);
    end else if (frame_height_q < HeightW'(2)) begin
      h_clamp = HeightW'(2);
    end else begin
      h_clamp = frame_height_q;
    end
    w_eff = {w_clamp[WidthW-1:1], 1'b0};
    h_eff = {h_clamp[HeightW-1:1], 1'b0};
  end

  logic [WidthW-1:0]  w_last;
  logic [HeightW-1:0] h_last;
  assign w_last = w_eff - WidthW'(1);
  assign h_last = h_eff - HeightW'(1);

  logic [ByteW-1:0] mem [yuvrgb_pkg::FrameDepth];
  logic [ByteW-1:0] rdata_q;
  logic [AddrW-1:0] rd_addr_q;
  logic             mem_we;

  assign mem_we = cmd_i.wr_mem && (byte_offset_i < AddrW'(yuvrgb_pkg::FrameDepth));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[byte_offset_i] <= byte_value_i;
    end
    rdata_q <= mem[rd_addr_q];
  end

  logic [WidthW-1:0]      xc_q;
  logic [HeightW-1:0]     yc_q;
  logic [AddrW-1:0]       ysize_q;
  logic [AddrW-1:0]       caddr_q;
  logic [ByteW-1:0]       y_q;
  logic [ByteW-1:0]       u_q;
  logic signed [SumW-1:0] base_q, re_q, ge_q, be_q;
  logic [ByteW-1:0]       red_q, green_q, blue_q;

  logic signed [9:0]      c_val, gain, d_val, e_val;

  always_comb begin
    gain  = (range_mode_q == yuvrgb_pkg::ModeStudio) ? 10'sd298 : 10'sd266;
    c_val = $signed({2'b00, y_q}) -
            ((range_mode_q == yuvrgb_pkg::ModeStudio) ? 10'sd16 : 10'sd0);
    d_val = $signed({2'b00, u_q}) - 10'sd128;
    e_val = $signed({2'b00, rdata_q}) - 10'sd128;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xc_q <= (pixel_x_i > w_last) ? w_last : pixel_x_i;
      yc_q <= (pixel_y_i > h_last) ? h_last : pixel_y_i;
    end
    if (cmd_i.yaddr) begin
      rd_addr_q <= AddrW'(yc_q) * AddrW'(w_eff) + AddrW'(xc_q);
    end
    if (cmd_i.size) begin
      ysize_q <= AddrW'(w_eff) * AddrW'(h_eff);
    end
    if (cmd_i.caddr) begin
      y_q     <= rdata_q;
      caddr_q <= AddrW'(yc_q[HeightW-1:1]) * AddrW'(w_eff[WidthW-1:1])
                 + AddrW'(xc_q[WidthW-1:1]);
    end
    if (cmd_i.uaddr) begin
      rd_addr_q <= ysize_q + caddr_q;
    end
    if (cmd_i.vaddr) begin
      rd_addr_q <= ysize_q + (ysize_q >> 2) + caddr_q;
    end
    if (cmd_i.uget) begin
      u_q <= rdata_q;
    end
    if (cmd_i.math) begin
      base_q <= SumW'(gain) * SumW'(c_val) + 20'sd128;
      re_q   <= SumW'(e_val) * 20'sd409;
      ge_q   <= SumW'(d_val) * 20'sd100 + SumW'(e_val) * 20'sd208;
      be_q   <= SumW'(d_val) * 20'sd516;
    end
    if (cmd_i.sum) begin
      red_q   <= clip8(base_q + re_q);
      green_q <= clip8(base_q - ge_q);
      blue_q  <= clip8(base_q + be_q);
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ----- design/yuvrgb_checker.sv -----
// Checker: port-level properties of the YUV to RGB top level, bound to it.
module yuvrgb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic command_i,
  input logic valid_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  a_busy_from_convert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && command_i == yuvrgb_pkg::CmdConvert))
    else $error("busy rose without a convert item");

  a_store_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == yuvrgb_pkg::CmdStore) |=> !busy_o)
    else $error("store item raised busy");

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result strobe without work in progress");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind yuv420p_frame_to_rgb_pixel_top yuvrgb_checker u_yuvrgb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .command_i (command_i),
  .valid_o   (valid_o)
);
